[hdl/shlk_pkg.sv]
// Shared types and constants for the signal handler priority lookup block.
package shlk_pkg;

	localparam int CODE_W = 16;
	localparam int NUM_W  = 5;
	localparam int OP_W   = 2;
	localparam int LVL_W  = 2;

	// Round-down constants and reciprocals (scaled by 2^RECIP_SHIFT, rounded up)
	localparam int HUND        = 100;
	localparam int THOU        = 1000;
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_HUND  = 10486;
	localparam int RECIP_THOU  = 1049;

	typedef enum logic [OP_W-1:0] {
		OP_RAISE  = 2'd0,
		OP_BIND   = 2'd1,
		OP_ENABLE = 2'd2
	} op_t;

	typedef enum logic [LVL_W-1:0] {
		LVL_NONE  = 2'd0,
		LVL_EXACT = 2'd1,
		LVL_HUND  = 2'd2,
		LVL_THOU  = 2'd3
	} lvl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic exact;
		logic hund;
		logic thou;
	} match_t;

endpackage

[hdl/shlk_if.sv]
// Valid/ready channel interfaces for request and response transactions.
interface shlk_in_if;
	logic                          valid;
	logic                          ready;
	logic [shlk_pkg::OP_W-1:0]     opcode;
	logic [shlk_pkg::CODE_W-1:0]   signal_code;
	logic [shlk_pkg::NUM_W-1:0]    entry_number;

	modport source (output valid, opcode, signal_code, entry_number, input ready);
	modport sink   (input valid, opcode, signal_code, entry_number, output ready);
endinterface

interface shlk_out_if;
	logic                          valid;
	logic                          ready;
	logic                          handled;
	logic [shlk_pkg::LVL_W-1:0]    match_level;
	logic [shlk_pkg::NUM_W-1:0]    winning_entry;
	logic [shlk_pkg::CODE_W-1:0]   status_code;
	logic                          bad_index;

	modport source (output valid, handled, match_level, winning_entry, status_code, bad_index,
		input ready);
	modport sink   (input valid, handled, match_level, winning_entry, status_code, bad_index,
		output ready);
endinterface

[hdl/shlk_round.sv]
// Two-stage round-down of a code to multiples of 100 and 1000.
module shlk_round (
	input  logic                        clk,
	input  logic [shlk_pkg::CODE_W-1:0] code,
	output logic [shlk_pkg::CODE_W-1:0] hund,
	output logic [shlk_pkg::CODE_W-1:0] thou
);

	// code must stay stable for both stages
	logic [29:0] prod_h;
	logic [26:0] prod_t;
	logic [9:0]  quot_h_s1;
	logic [6:0]  quot_t_s1;
	logic [16:0] back_h;
	logic [16:0] back_t;
	logic [16:0] fix_h;
	logic [16:0] fix_t;
	logic [15:0] hund_s2;
	logic [15:0] thou_s2;

	assign prod_h = 30'(code) * 30'(shlk_pkg::RECIP_HUND);
	assign prod_t = 27'(code) * 27'(shlk_pkg::RECIP_THOU);

	always_ff @(posedge clk) begin
		quot_h_s1 <= prod_h[29:20];
		quot_t_s1 <= prod_t[26:20];
	end

	// quotient estimate is exact or one too high
	assign back_h = 17'(quot_h_s1) * 17'(shlk_pkg::HUND);
	assign back_t = 17'(quot_t_s1) * 17'(shlk_pkg::THOU);
	assign fix_h  = (back_h > 17'(code)) ? back_h - 17'(shlk_pkg::HUND) : back_h;
	assign fix_t  = (back_t > 17'(code)) ? back_t - 17'(shlk_pkg::THOU) : back_t;

	always_ff @(posedge clk) begin
		hund_s2 <= fix_h[15:0];
		thou_s2 <= fix_t[15:0];
	end

	assign hund = hund_s2;
	assign thou = thou_s2;

endmodule

[hdl/shlk_code_mem.sv]
// Entry code memory: one write port, one registered read port.
module shlk_code_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [shlk_pkg::CODE_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [shlk_pkg::CODE_W-1:0] rdata
);

	logic [shlk_pkg::CODE_W-1:0] mem [DEPTH];
	logic [shlk_pkg::CODE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/shlk_match.sv]
// Shared compare unit: entry code against raised code and its rounded groups.
module shlk_match (
	input  logic [shlk_pkg::CODE_W-1:0] entry_code,
	input  logic [shlk_pkg::CODE_W-1:0] code,
	input  logic [shlk_pkg::CODE_W-1:0] hund,
	input  logic [shlk_pkg::CODE_W-1:0] thou,
	output shlk_pkg::match_t            hit
);

	assign hit.exact = (entry_code == code);
	assign hit.hund  = (entry_code == hund);
	assign hit.thou  = (entry_code == thou);

endmodule

[hdl/signal_handler_priority_lookup.sv]
// Signal handler table with prioritized lookup: top level and sequencer.
//
// Each entry holds a bound flag, a 16-bit code and an enabled flag. A raise
// transaction walks the bound, enabled entries among the first entries_in_use
// (capped at ENTRIES) one per cycle through a single compare unit; the first
// exact code match wins, else the last entry holding the code rounded down to
// a hundred, else the last one holding it rounded down to a thousand. The
// winner is disabled and reported. A bind walks the same range to unbind
// any bound entry with the same code, then binds the chosen entry. An enable
// transaction sets one entry's enabled flag. Bind or enable naming entry 0 or
// an entry past the count reports bad_index and changes nothing.
// Raise and valid bind walk the effective count of entries; other requests
// walk none. Steps: the first round-down stage (ST_DIV), then the walk
// (reads issued, the last compare, a check that the walk has drained; the
// second round-down stage overlaps the first read), then the update in
// ST_DONE, which waits while an older result has not been taken. The request
// side is ready again the cycle after that, and a new request is taken only
// once the previous one is through. The response register frees the request
// side while a result waits to be taken. Codes are held in a memory, and
// read values are only used for bound entries, so no clearing pass is needed.
module signal_handler_priority_lookup #(
	parameter int ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [shlk_pkg::NUM_W-1:0] cfg_wdata,
	shlk_in_if.sink                    req,
	shlk_out_if.source                 rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	shlk_pkg::state_t state_q, state_nxt;

	// configuration
	logic [shlk_pkg::NUM_W-1:0]  cnt_cfg_q;
	logic [shlk_pkg::NUM_W-1:0]  count_eff;

	// current transaction
	logic [shlk_pkg::OP_W-1:0]   op_q;
	logic [shlk_pkg::CODE_W-1:0] code_q;
	logic [shlk_pkg::NUM_W-1:0]  num_q;
	logic                        bad_q;
	logic [shlk_pkg::NUM_W-1:0]  lim_q;
	logic                        req_bad;
	logic                        req_scan;

	// walk: issue stage and check stage
	logic [shlk_pkg::NUM_W-1:0]  scan_q;
	logic                        chk_vld_s1;
	logic [shlk_pkg::NUM_W-1:0]  chk_idx_s1;
	logic                        issue_more;
	logic [AW-1:0]               chk_a;

	// running winners
	logic                        found_exact_q;
	logic [shlk_pkg::NUM_W-1:0]  win_exact_q;
	logic [shlk_pkg::NUM_W-1:0]  win_hund_q;
	logic [shlk_pkg::NUM_W-1:0]  win_thou_q;

	// entry flags
	logic [ENTRIES-1:0]          bound_q;
	logic [ENTRIES-1:0]          enabled_q;

	// datapath
	logic [shlk_pkg::CODE_W-1:0] hund;
	logic [shlk_pkg::CODE_W-1:0] thou;
	logic [shlk_pkg::CODE_W-1:0] mem_rdata;
	shlk_pkg::match_t            hit;
	logic                        mem_we;
	logic [AW-1:0]               num_a;

	// result
	shlk_pkg::lvl_t              lvl;
	logic [shlk_pkg::NUM_W-1:0]  win;
	logic [AW-1:0]               win_a;
	logic                        req_ready;
	logic                        done_fire;

	logic                        rsp_valid_q;
	logic                        rsp_handled_q;
	logic [shlk_pkg::LVL_W-1:0]  rsp_level_q;
	logic [shlk_pkg::NUM_W-1:0]  rsp_winner_q;
	logic [shlk_pkg::CODE_W-1:0] rsp_status_q;
	logic                        rsp_bad_q;

	// count above table size acts as the table size
	assign count_eff = (32'(cnt_cfg_q) > ENTRIES) ? shlk_pkg::NUM_W'(ENTRIES) : cnt_cfg_q;

	assign req_bad  = ((req.opcode == shlk_pkg::OP_BIND) || (req.opcode == shlk_pkg::OP_ENABLE))
		&& ((req.entry_number == '0) || (req.entry_number > count_eff));
	assign req_scan = (req.opcode == shlk_pkg::OP_RAISE)
		|| ((req.opcode == shlk_pkg::OP_BIND) && !req_bad);

	assign issue_more = (scan_q < lim_q);
	assign chk_a      = AW'(chk_idx_s1);
	assign num_a      = AW'(num_q - 5'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_cfg_q <= 5'd16;
		end else if (cfg_we) begin
			cnt_cfg_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shlk_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		done_fire = 1'b0;
		case (state_q)
			shlk_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_nxt = shlk_pkg::ST_DIV;
				end
			end
			shlk_pkg::ST_DIV: begin
				state_nxt = shlk_pkg::ST_SCAN;
			end
			shlk_pkg::ST_SCAN: begin
				if (!issue_more && !chk_vld_s1) begin
					state_nxt = shlk_pkg::ST_DONE;
				end
			end
			shlk_pkg::ST_DONE: begin
				// hold while an older result still waits
				if (!rsp_valid_q || rsp.ready) begin
					done_fire = 1'b1;
					state_nxt = shlk_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = shlk_pkg::ST_IDLE;
			end
		endcase
	end

	assign req.ready = req_ready;

	// transaction latch
	always_ff @(posedge clk) begin
		if (req_ready && req.valid) begin
			op_q   <= req.opcode;
			code_q <= req.signal_code;
			num_q  <= req.entry_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q         <= 1'b0;
			lim_q         <= '0;
			scan_q        <= '0;
			chk_vld_s1    <= 1'b0;
			chk_idx_s1    <= '0;
			found_exact_q <= 1'b0;
			win_exact_q   <= '0;
			win_hund_q    <= '0;
			win_thou_q    <= '0;
		end else begin
			if (req_ready && req.valid) begin
				bad_q         <= req_bad;
				lim_q         <= req_scan ? count_eff : '0;
				scan_q        <= '0;
				chk_vld_s1    <= 1'b0;
				found_exact_q <= 1'b0;
				win_exact_q   <= '0;
				win_hund_q    <= '0;
				win_thou_q    <= '0;
			end else if (state_q == shlk_pkg::ST_SCAN) begin
				chk_vld_s1 <= issue_more;
				chk_idx_s1 <= scan_q;
				if (issue_more) begin
					scan_q <= scan_q + 5'd1;
				end
				// raise: first exact wins, later group hits overwrite
				if (chk_vld_s1 && (op_q == shlk_pkg::OP_RAISE) && bound_q[chk_a]
					&& enabled_q[chk_a] && !found_exact_q) begin
					if (hit.exact) begin
						found_exact_q <= 1'b1;
						win_exact_q   <= chk_idx_s1 + 5'd1;
					end else if (hit.hund) begin
						win_hund_q <= chk_idx_s1 + 5'd1;
					end else if (hit.thou) begin
						win_thou_q <= chk_idx_s1 + 5'd1;
					end
				end
			end
		end
	end

	shlk_round u_round (
		.clk  (clk),
		.code (code_q),
		.hund (hund),
		.thou (thou)
	);

	assign mem_we = done_fire && (op_q == shlk_pkg::OP_BIND) && !bad_q;

	shlk_code_mem #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_code_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (num_a),
		.wdata (code_q),
		.raddr (AW'(scan_q)),
		.rdata (mem_rdata)
	);

	shlk_match u_match (
		.entry_code (mem_rdata),
		.code       (code_q),
		.hund       (hund),
		.thou       (thou),
		.hit        (hit)
	);

	// winner selection by priority level
	always_comb begin
		lvl = shlk_pkg::LVL_NONE;
		win = '0;
		if (found_exact_q) begin
			lvl = shlk_pkg::LVL_EXACT;
			win = win_exact_q;
		end else if (win_hund_q != '0) begin
			lvl = shlk_pkg::LVL_HUND;
			win = win_hund_q;
		end else if (win_thou_q != '0) begin
			lvl = shlk_pkg::LVL_THOU;
			win = win_thou_q;
		end
	end

	assign win_a = AW'(win - 5'd1);

	// entry flags: unbind during the bind walk, final update at done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q   <= '0;
			enabled_q <= '0;
		end else begin
			if ((state_q == shlk_pkg::ST_SCAN) && chk_vld_s1 && (op_q == shlk_pkg::OP_BIND)
				&& bound_q[chk_a] && hit.exact) begin
				bound_q[chk_a] <= 1'b0;
			end
			if (done_fire) begin
				case (op_q)
					shlk_pkg::OP_RAISE: begin
						if (win != '0) begin
							enabled_q[win_a] <= 1'b0;
						end
					end
					shlk_pkg::OP_BIND: begin
						if (!bad_q) begin
							bound_q[num_a] <= 1'b1;
						end
					end
					shlk_pkg::OP_ENABLE: begin
						if (!bad_q) begin
							enabled_q[num_a] <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			if ((op_q == shlk_pkg::OP_RAISE) && (win != '0)) begin
				rsp_handled_q <= 1'b1;
				rsp_level_q   <= lvl;
				rsp_winner_q  <= win;
				rsp_status_q  <= code_q;
			end else begin
				rsp_handled_q <= 1'b0;
				rsp_level_q   <= shlk_pkg::LVL_NONE;
				rsp_winner_q  <= '0;
				rsp_status_q  <= '0;
			end
			rsp_bad_q <= bad_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.handled       = rsp_handled_q;
	assign rsp.match_level   = rsp_level_q;
	assign rsp.winning_entry = rsp_winner_q;
	assign rsp.status_code   = rsp_status_q;
	assign rsp.bad_index     = rsp_bad_q;

`ifndef ASSERT_OFF
	// a bad index never comes with a hit
	a_bad_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> !(rsp_bad_q && rsp_handled_q))
		else $error("bad_index reported together with a handled raise");

	// handled, level and winner agree
	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> ((rsp_handled_q == (rsp_level_q != shlk_pkg::LVL_NONE))
			&& (rsp_handled_q == (rsp_winner_q != '0))))
		else $error("inconsistent handled, match_level and winning_entry");

	// walk never checks past the limit
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (chk_idx_s1 < lim_q))
		else $error("entry checked beyond the walk limit");

	// first exact match is never overwritten
	a_exact_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(found_exact_q && (state_q == shlk_pkg::ST_SCAN)) |=> $stable(win_exact_q))
		else $error("exact winner changed after it was found");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the signal handler priority lookup block.
module tb;

	localparam int ENTRIES     = 16;
	localparam int CODE_MAX    = 2**shlk_pkg::CODE_W - 1;
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int STALL_LIMIT = 5000;  // cycles with no transaction before giving up
	localparam int DRAIN_WAIT  = 30;    // settle time after the last result

	// opcode 3 has no meaning; the block must answer with an all-zero result
	localparam logic [shlk_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	// One expected result, laid out like the response channel
	typedef struct packed {
		logic                        handled;
		shlk_pkg::lvl_t              level;
		logic [shlk_pkg::NUM_W-1:0]  winner;
		logic [shlk_pkg::CODE_W-1:0] status;
		logic                        bad;
	} lookup_res_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [shlk_pkg::NUM_W-1:0] cfg_wdata;

	shlk_in_if  req_if ();
	shlk_out_if rsp_if ();

	signal_handler_priority_lookup #(.ENTRIES(ENTRIES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the handler table and the entries_in_use register.
	// Updated in transaction order as requests are accepted.
	// ------------------------------------------------------------------
	logic                        tbl_bound   [ENTRIES] = '{default: 1'b0};
	logic [shlk_pkg::CODE_W-1:0] tbl_code    [ENTRIES] = '{default: '0};
	logic                        tbl_enabled [ENTRIES] = '{default: 1'b0};
	logic [shlk_pkg::NUM_W-1:0]  tbl_limit = 5'd16;

	lookup_res_t pending_lookups[$];   // expected results, oldest first

	int err_cnt      = 0;
	int req_cnt      = 0;
	int lvl_seen [4] = '{default: 0};  // raises by match level
	int bad_seen     = 0;
	int unused_seen  = 0;

	bit no_idle      = 1'b0;  // turns off random idling on both sides
	bit rsp_hold_req = 1'b0;  // asks the receiver for one long hold-off

	// Effective entry count: anything above the table size acts as the table size
	function automatic int active_entries();
		return (tbl_limit > ENTRIES) ? ENTRIES : int'(tbl_limit);
	endfunction

	// Predict the result of one request and apply its side effects to the shadow table
	function automatic lookup_res_t predict_lookup(input logic [shlk_pkg::OP_W-1:0] op,
			input logic [shlk_pkg::CODE_W-1:0] code, input logic [shlk_pkg::NUM_W-1:0] num);
		lookup_res_t                 r;
		int                          lim;
		int                          hit_exact, hit_hund, hit_thou;
		logic [shlk_pkg::CODE_W-1:0] hund_c, thou_c;
		r         = '0;
		lim       = active_entries();
		hit_exact = 0;
		hit_hund  = 0;
		hit_thou  = 0;
		hund_c    = shlk_pkg::CODE_W'((int'(code) / shlk_pkg::HUND) * shlk_pkg::HUND);
		thou_c    = shlk_pkg::CODE_W'((int'(code) / shlk_pkg::THOU) * shlk_pkg::THOU);
		if (op == shlk_pkg::OP_RAISE) begin
			// first exact match stops the walk; group matches keep the last hit
			for (int i = 0; i < lim; i++) begin
				if (tbl_bound[i] && tbl_enabled[i]) begin
					if (tbl_code[i] == code) begin
						hit_exact = i + 1;
						break;
					end else if (tbl_code[i] == hund_c) begin
						hit_hund = i + 1;
					end else if (tbl_code[i] == thou_c) begin
						hit_thou = i + 1;
					end
				end
			end
			if (hit_exact != 0) begin
				r.level  = shlk_pkg::LVL_EXACT;
				r.winner = shlk_pkg::NUM_W'(hit_exact);
			end else if (hit_hund != 0) begin
				r.level  = shlk_pkg::LVL_HUND;
				r.winner = shlk_pkg::NUM_W'(hit_hund);
			end else if (hit_thou != 0) begin
				r.level  = shlk_pkg::LVL_THOU;
				r.winner = shlk_pkg::NUM_W'(hit_thou);
			end
			if (r.level != shlk_pkg::LVL_NONE) begin
				r.handled = 1'b1;
				r.status  = code;
				tbl_enabled[r.winner - 1] = 1'b0;
			end
			lvl_seen[r.level]++;
		end else if (op == shlk_pkg::OP_BIND || op == shlk_pkg::OP_ENABLE) begin
			if (num == 0 || num > lim) begin
				r.bad = 1'b1;
				bad_seen++;
			end else if (op == shlk_pkg::OP_BIND) begin
				// a code lives in one entry at a time within the active range
				for (int i = 0; i < lim; i++)
					if (tbl_bound[i] && tbl_code[i] == code)
						tbl_bound[i] = 1'b0;
				tbl_bound[num - 1] = 1'b1;
				tbl_code[num - 1]  = code;
			end else begin
				tbl_enabled[num - 1] = 1'b1;
			end
		end else begin
			unused_seen++;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Valid stays high from one transaction into the next
	// unless a random idle cycle is inserted, so back-to-back items never
	// see valid drop and rise within one time step.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [shlk_pkg::OP_W-1:0] op,
			input logic [shlk_pkg::CODE_W-1:0] code, input logic [shlk_pkg::NUM_W-1:0] num);
		if (!no_idle && $urandom_range(0, 99) < 16) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 16)
				@(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.opcode       <= op;
		req_if.signal_code  <= code;
		req_if.entry_number <= num;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		// accepted at this edge: predict right away so the queue order is exact
		pending_lookups.push_back(predict_lookup(op, code, num));
		req_cnt++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_idle();
		req_if.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write, only with the block idle
	task automatic set_count(input logic [shlk_pkg::NUM_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tbl_limit = value;
	endtask

	// ------------------------------------------------------------------
	// Response side: ready pattern, one long hold-off on request, checker
	// ------------------------------------------------------------------
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_if.ready <= no_idle || ($urandom_range(0, 99) >= 16);
		end
	end

	always @(posedge clk) begin
		lookup_res_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_lookups.size() == 0) begin
				$error("result transaction with nothing expected");
				err_cnt++;
			end else begin
				want = pending_lookups.pop_front();
				if (rsp_if.handled !== want.handled) begin
					$error("handled: expected %0d, got %0d", want.handled, rsp_if.handled);
					err_cnt++;
				end
				if (rsp_if.match_level !== want.level) begin
					$error("match_level: expected %0d, got %0d", want.level,
						rsp_if.match_level);
					err_cnt++;
				end
				if (rsp_if.winning_entry !== want.winner) begin
					$error("winning_entry: expected %0d, got %0d", want.winner,
						rsp_if.winning_entry);
					err_cnt++;
				end
				if (rsp_if.status_code !== want.status) begin
					$error("status_code: expected %0d, got %0d", want.status,
						rsp_if.status_code);
					err_cnt++;
				end
				if (rsp_if.bad_index !== want.bad) begin
					$error("bad_index: expected %0d, got %0d", want.bad, rsp_if.bad_index);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Empty table right after reset, unused opcode, invalid entry numbers
	task automatic test_reset_state();
		send_item(shlk_pkg::OP_RAISE, 16'h0000, 5'd0);
		send_item(OP_UNUSED, 16'hFFFF, 5'd31);
		send_item(shlk_pkg::OP_BIND, 16'h1234, 5'd0);
		send_item(shlk_pkg::OP_ENABLE, 16'h0042, 5'd17);
	endtask

	// Exact match at both ends of the table; the winner gets disabled
	task automatic test_exact_match();
		send_item(shlk_pkg::OP_BIND, 16'hFFFF, 5'd1);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd1);
		send_item(shlk_pkg::OP_RAISE, 16'hFFFF, 5'd0);
		send_item(shlk_pkg::OP_RAISE, 16'hFFFF, 5'd0);   // now disabled, so unhandled
		send_item(shlk_pkg::OP_BIND, 16'd1234, 5'd16);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd16);
		send_item(shlk_pkg::OP_RAISE, 16'd1234, 5'd0);
	endtask

	// Rebinding a code moves it; hundred and thousand groups; code zero
	task automatic test_group_match();
		send_item(shlk_pkg::OP_BIND, 16'd1200, 5'd2);
		send_item(shlk_pkg::OP_BIND, 16'd1200, 5'd5);    // unbinds entry 2
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd2);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd5);
		send_item(shlk_pkg::OP_BIND, 16'd1000, 5'd3);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd3);
		send_item(shlk_pkg::OP_RAISE, 16'd1250, 5'd0);   // hundred group, entry 5
		send_item(shlk_pkg::OP_RAISE, 16'd1999, 5'd0);   // thousand group, entry 3
		send_item(shlk_pkg::OP_BIND, 16'd0, 5'd4);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd4);
		send_item(shlk_pkg::OP_RAISE, 16'd99, 5'd0);     // code zero hit through the hundred group
	endtask

	// Register extremes: nothing addressable, and a count above the table size
	task automatic test_count_limits();
		set_count(5'd0);
		send_item(shlk_pkg::OP_BIND, 16'd7, 5'd1);
		send_item(shlk_pkg::OP_RAISE, 16'd1234, 5'd0);
		set_count(5'd31);
		send_item(shlk_pkg::OP_ENABLE, 16'h0000, 5'd16);
		set_count(5'd16);
	endtask

	// Receiver holds off long enough for the block to fill and stall its input
	task automatic test_backpressure();
		wait_idle();
		rsp_hold_req = 1'b1;
		for (int k = 0; k < 12; k++) begin
			if (k % 2 == 0)
				send_item(shlk_pkg::OP_ENABLE, 16'h0000, shlk_pkg::NUM_W'(k + 1));
			else
				send_item(shlk_pkg::OP_RAISE, 16'd1250, 5'd0);
		end
		// sender pauses until every result has come back
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Random traffic: mostly binds, enables and raises aimed at bound codes
	// so the search gets real hits, plus noise with arbitrary fields.
	// ------------------------------------------------------------------
	task automatic random_items(input int n);
		int                          pick, sel, idx, lim, base, val;
		logic [shlk_pkg::OP_W-1:0]   op;
		logic [shlk_pkg::CODE_W-1:0] code;
		logic [shlk_pkg::NUM_W-1:0]  num;
		repeat (n) begin
			lim  = active_entries();
			pick = $urandom_range(0, 99);
			sel  = $urandom_range(0, 99);
			idx  = $urandom_range(0, ENTRIES - 1);
			code = shlk_pkg::CODE_W'($urandom_range(0, CODE_MAX));
			num  = shlk_pkg::NUM_W'($urandom_range(0, 31));
			if (pick < 5) begin
				// noise: any entry number, any code, sometimes the unused opcode
				case ($urandom_range(0, 2))
					0:       op = OP_UNUSED;
					1:       op = shlk_pkg::OP_BIND;
					default: op = shlk_pkg::OP_ENABLE;
				endcase
			end else if (pick < 30) begin
				op = shlk_pkg::OP_BIND;
				// round codes make the group searches hit; reusing a code tests unbinding
				val = $urandom_range(0, 65) * shlk_pkg::THOU;
				if (sel < 15 && tbl_bound[idx])
					val = tbl_code[idx];
				else if (sel >= 55 && sel < 80)
					val = val + $urandom_range(0, 9) * shlk_pkg::HUND;
				else if (sel >= 80)
					val = val + $urandom_range(0, shlk_pkg::THOU - 1);
				code = shlk_pkg::CODE_W'((val > CODE_MAX) ? CODE_MAX : val);
				if (lim > 0)
					num = shlk_pkg::NUM_W'($urandom_range(1, lim));
			end else if (pick < 60) begin
				op = shlk_pkg::OP_ENABLE;
				if (lim > 0)
					num = shlk_pkg::NUM_W'($urandom_range(1, lim));
			end else begin
				op = shlk_pkg::OP_RAISE;
				if (sel < 70 && tbl_bound[idx]) begin
					base = tbl_code[idx];
					case ($urandom_range(0, 2))
						0:       val = base;
						1:       val = base / shlk_pkg::HUND * shlk_pkg::HUND
							+ $urandom_range(0, shlk_pkg::HUND - 1);
						default: val = base / shlk_pkg::THOU * shlk_pkg::THOU
							+ $urandom_range(0, shlk_pkg::THOU - 1);
					endcase
					code = shlk_pkg::CODE_W'((val > CODE_MAX) ? base : val);
				end
			end
			send_item(op, code, num);
		end
	endtask

	task automatic test_random_mix();
		set_count(5'd16);
		random_items(200);
		set_count(5'd4);
		random_items(80);
		// a stretch without any idling on either side
		set_count(5'd31);
		no_idle = 1'b1;
		random_items(100);
		no_idle = 1'b0;
		set_count(5'd1);
		random_items(40);
		set_count(5'd0);
		random_items(20);
		set_count(5'd10);
		random_items(100);
		set_count(5'd16);
		random_items(160);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= '0;
		req_if.valid        <= 1'b0;
		req_if.opcode       <= '0;
		req_if.signal_code  <= '0;
		req_if.entry_number <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_exact_match();
		test_group_match();
		test_count_limits();
		test_backpressure();
		test_random_mix();

		wait_idle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_lookups.size() != 0) begin
			$error("%0d expected results never arrived", pending_lookups.size());
			err_cnt++;
		end

		$display("run: %0d transactions; raises exact %0d, hundred %0d, thousand %0d, none %0d",
			req_cnt, lvl_seen[shlk_pkg::LVL_EXACT], lvl_seen[shlk_pkg::LVL_HUND],
			lvl_seen[shlk_pkg::LVL_THOU], lvl_seen[shlk_pkg::LVL_NONE]);
		$display("run: bad index %0d, unused opcode %0d, counts 0/1/4/10/16/31, long hold-off",
			bad_seen, unused_seen);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
